FILE: hdl/ij2s_pkg.sv
// Shared types, codes and the kanji pair conversion for the ISO-2022-JP to Shift-JIS converter.
package ij2s_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] DOLLAR_BYTE = 8'h24;
  localparam logic [7:0] PAREN_BYTE  = 8'h28;

  localparam logic [7:0] ESCAPE_FINAL_RESET = 8'h42;

  localparam logic [7:0]  ODD_ROW_ADJ  = 8'h40 - 8'h21;
  localparam logic [7:0]  EVEN_ROW_ADJ = 8'h9E - 8'h21;
  localparam logic [7:0]  TRAIL_GAP    = 8'h7F;
  localparam logic [15:0] ROW_BIAS     = 16'h0021;
  localparam logic [15:0] LEAD_BASE    = 16'h0081;
  localparam logic [15:0] LEAD_GAP     = 16'h00A0;
  localparam logic [15:0] LEAD_SKIP    = 16'h0040;

  localparam int MAX_RESULTS = 3;

  // escape progress codes
  localparam logic [1:0] EP_NONE   = 2'd0;
  localparam logic [1:0] EP_ESC    = 2'd1;
  localparam logic [1:0] EP_DOLLAR = 2'd2;
  localparam logic [1:0] EP_SKIP   = 2'd3;

  typedef struct packed {
    logic       kanji;
    logic [1:0] esc_prog;
    logic       pair_pend;
    logic [7:0] first_byte;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
  } result_t;

  typedef struct packed {
    logic [1:0]                        cnt;
    result_t [MAX_RESULTS-1:0]         ent;
  } group_t;

  function automatic logic [15:0] convert_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] w1;
    logic [7:0]  w2;
    w2 = {1'b0, lo[6:0]} + (hi[0] ? ODD_ROW_ADJ : EVEN_ROW_ADJ);
    if (w2 >= TRAIL_GAP) begin
      w2 = w2 + 8'd1;
    end
    w1 = ({9'd0, hi[6:0]} - ROW_BIAS) >> 1;
    w1 = w1 + LEAD_BASE;
    if (w1 >= LEAD_GAP) begin
      w1 = w1 + LEAD_SKIP;
    end
    return {w1[7:0], w2};
  endfunction

endpackage

FILE: hdl/ij2s_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface ij2s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;
  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ij2s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  output ready);
endinterface

interface ij2s_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/iso2022jp_to_shift_jis_converter.sv
// Top level: ISO-2022-JP / JIS byte stream to Shift-JIS byte stream converter.
// One input word per cycle is taken while each byte yields at most one result and
// out_ch.ready is high; a byte that yields k results (0 to 3) holds the result register
// until all k are taken, and throughput is otherwise set by the single-word result port.
// A byte passes the input register, then the result register. The escape, mode and pair
// state updates with each accepted byte, so bytes stream back to back.
// Configuration writes are always accepted and should be made while the block is idle.
module iso2022jp_to_shift_jis_converter (
  input  logic        clk,
  input  logic        rst_n,
  ij2s_in_if.sink     in_ch,
  ij2s_out_if.source  out_ch,
  ij2s_cfg_if.sink    cfg_ch
);

  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic             in_vld_r;
  logic             in_vld_nxt;
  logic [7:0]       esc_final_r;
  ij2s_pkg::state_t st_r;
  ij2s_pkg::state_t st_nxt;
  ij2s_pkg::group_t grp;
  logic             can_load;
  logic             proc_fire;
  logic             in_fire;

  assign proc_fire    = in_vld_r && ((grp.cnt == 2'd0) || can_load);
  assign in_ch.ready  = !in_vld_r || proc_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_fire) begin
      in_vld_nxt = 1'b1;
    end else if (proc_fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      st_r        <= '0;
      esc_final_r <= ij2s_pkg::ESCAPE_FINAL_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (proc_fire) begin
        st_r <= st_nxt;
      end
      if (cfg_ch.valid) begin
        esc_final_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.end_of_string;
    end
  end

  ij2s_decode u_decode (
    .st           (st_r),
    .data_byte    (in_byte_r),
    .last         (in_last_r),
    .escape_final (esc_final_r),
    .st_nxt       (st_nxt),
    .grp          (grp)
  );

  ij2s_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (proc_fire && (grp.cnt != 2'd0)),
    .grp      (grp),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_bare_marker_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid |-> out_ch.string_done)
    else $error("bare end marker without string_done");

  a_state_clears_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && in_last_r |=> st_r == '0)
    else $error("state not cleared after end of string");

  a_skip_is_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.esc_prog == ij2s_pkg::EP_SKIP |-> !st_r.kanji)
    else $error("skip pending while in kanji mode");

  a_pair_only_in_kanji: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pair_pend |-> st_r.kanji && (st_r.esc_prog == ij2s_pkg::EP_NONE))
    else $error("pair pending outside kanji mode or with escape held");

endmodule

FILE: hdl/ij2s_decode.sv
// Per-byte escape tracking, mode update and result generation.
module ij2s_decode (
  input  ij2s_pkg::state_t st,
  input  logic [7:0]       data_byte,
  input  logic             last,
  input  logic [7:0]       escape_final,
  output ij2s_pkg::state_t st_nxt,
  output ij2s_pkg::group_t grp
);

  logic [15:0] cv_held;
  logic [15:0] cv_dollar;

  assign cv_held   = ij2s_pkg::convert_pair(st.first_byte, data_byte);
  assign cv_dollar = ij2s_pkg::convert_pair(ij2s_pkg::DOLLAR_BYTE, data_byte);

  always_comb begin
    logic [7:0] eb [ij2s_pkg::MAX_RESULTS];
    logic [1:0] n;
    ij2s_pkg::state_t s;
    for (int k = 0; k < ij2s_pkg::MAX_RESULTS; k++) begin
      eb[k] = '0;
    end
    n = '0;
    s = st;
    unique case (st.esc_prog)
      ij2s_pkg::EP_ESC: begin
        if (data_byte == ij2s_pkg::DOLLAR_BYTE) begin
          s.esc_prog = ij2s_pkg::EP_DOLLAR;
        end else if (data_byte == ij2s_pkg::PAREN_BYTE) begin
          s.kanji    = 1'b0;
          s.esc_prog = ij2s_pkg::EP_SKIP;
        end else begin
          s.esc_prog = ij2s_pkg::EP_NONE;
          eb[n] = ij2s_pkg::ESC_BYTE; n = n + 2'd1;
          if (data_byte == ij2s_pkg::ESC_BYTE) begin
            s.esc_prog = ij2s_pkg::EP_ESC;
          end else if (st.kanji) begin
            s.pair_pend  = 1'b1;
            s.first_byte = data_byte;
          end else begin
            eb[n] = data_byte; n = n + 2'd1;
          end
        end
      end
      ij2s_pkg::EP_DOLLAR: begin
        s.esc_prog = ij2s_pkg::EP_NONE;
        if (data_byte == escape_final) begin
          s.kanji = 1'b1;
        end else begin
          eb[n] = ij2s_pkg::ESC_BYTE; n = n + 2'd1;
          if (st.kanji) begin
            // '$' opens a pair; this byte closes it, ESC or not
            eb[n] = cv_dollar[15:8]; n = n + 2'd1;
            eb[n] = cv_dollar[7:0];  n = n + 2'd1;
          end else begin
            eb[n] = ij2s_pkg::DOLLAR_BYTE; n = n + 2'd1;
            if (data_byte == ij2s_pkg::ESC_BYTE) begin
              s.esc_prog = ij2s_pkg::EP_ESC;
            end else begin
              eb[n] = data_byte; n = n + 2'd1;
            end
          end
        end
      end
      ij2s_pkg::EP_SKIP: begin
        s.esc_prog = ij2s_pkg::EP_NONE;
      end
      default: begin
        if (st.pair_pend) begin
          s.pair_pend  = 1'b0;
          s.first_byte = '0;
          eb[n] = cv_held[15:8]; n = n + 2'd1;
          eb[n] = cv_held[7:0];  n = n + 2'd1;
        end else if (data_byte == ij2s_pkg::ESC_BYTE) begin
          s.esc_prog = ij2s_pkg::EP_ESC;
        end else if (st.kanji) begin
          s.pair_pend  = 1'b1;
          s.first_byte = data_byte;
        end else begin
          eb[n] = data_byte; n = n + 2'd1;
        end
      end
    endcase

    if (last) begin
      if (s.esc_prog == ij2s_pkg::EP_ESC) begin
        eb[n] = ij2s_pkg::ESC_BYTE; n = n + 2'd1;
      end else if (s.esc_prog == ij2s_pkg::EP_DOLLAR) begin
        eb[n] = ij2s_pkg::ESC_BYTE;    n = n + 2'd1;
        eb[n] = ij2s_pkg::DOLLAR_BYTE; n = n + 2'd1;
      end
      s = '0;
    end

    st_nxt = s;
    for (int k = 0; k < ij2s_pkg::MAX_RESULTS; k++) begin
      grp.ent[k].out_byte    = eb[k];
      grp.ent[k].byte_valid  = 1'b1;
      grp.ent[k].string_done = last && (n == 2'(k + 1));
    end
    grp.cnt = n;
    if (last && (n == 2'd0)) begin
      grp.ent[0] = '{out_byte: 8'd0, byte_valid: 1'b0, string_done: 1'b1};
      grp.cnt    = 2'd1;
    end
  end

endmodule

FILE: hdl/ij2s_outbuf.sv
// Result register that holds one byte's results and hands them out a word per cycle while out_ch.ready is high.
module ij2s_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ij2s_pkg::group_t    grp,
  output logic                can_load,
  ij2s_out_if.source          out_ch
);

  ij2s_pkg::group_t grp_r;
  logic [1:0]       idx_r;
  logic [1:0]       idx_nxt;
  logic             vld_r;
  logic             vld_nxt;
  logic             pop;
  logic             pop_last;

  assign pop      = vld_r && out_ch.ready;
  assign pop_last = pop && (idx_r == grp_r.cnt - 2'd1);
  assign can_load = !vld_r || pop_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = '0;
      vld_nxt = 1'b1;
    end else if (pop_last) begin
      idx_nxt = '0;
      vld_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.out_byte    = grp_r.ent[idx_r].out_byte;
  assign out_ch.byte_valid  = grp_r.ent[idx_r].byte_valid;
  assign out_ch.string_done = grp_r.ent[idx_r].string_done;

endmodule

FILE: verif/sjis_stream_checker.sv
// Scoreboard for the ISO-2022-JP to Shift-JIS converter: predicts result words and checks them.
module sjis_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_done,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         awaited,
  output int         checked
);

  ij2s_pkg::result_t sjis_expected[$];
  logic [7:0]        emitted[$];

  logic [7:0] esc_final_q;
  logic       kanji_q;
  logic [1:0] esc_stage_q;
  logic       lead_held_q;
  logic [7:0] lead_q;

  task automatic clear_stream_state();
    kanji_q     = 1'b0;
    esc_stage_q = ij2s_pkg::EP_NONE;
    lead_held_q = 1'b0;
    lead_q      = 8'h00;
  endtask

  // byte with no escape in progress
  task automatic take_plain(input logic [7:0] b);
    logic [15:0] row;
    logic [15:0] col;
    if (lead_held_q) begin
      lead_held_q = 1'b0;
      row = {9'd0, lead_q[6:0]};
      col = {9'd0, b[6:0]};
      col = col + (row[0] ? 16'h001F : 16'h007D);
      if (col >= 16'h007F) begin
        col = col + 16'd1;
      end
      row = (row - 16'h0021) >> 1;
      row = row + 16'h0081;
      if (row >= 16'h00A0) begin
        row = row + 16'h0040;
      end
      emitted.push_back(row[7:0]);
      emitted.push_back(col[7:0]);
      lead_q = 8'h00;
    end else if (b == ij2s_pkg::ESC_BYTE) begin
      esc_stage_q = ij2s_pkg::EP_ESC;
    end else if (kanji_q) begin
      lead_held_q = 1'b1;
      lead_q      = b;
    end else begin
      emitted.push_back(b);
    end
  endtask

  task automatic predict_sjis(input logic [7:0] b, input logic last);
    ij2s_pkg::result_t r;
    int                n;
    emitted.delete();
    case (esc_stage_q)
      ij2s_pkg::EP_ESC: begin
        if (b == ij2s_pkg::DOLLAR_BYTE) begin
          esc_stage_q = ij2s_pkg::EP_DOLLAR;
        end else if (b == ij2s_pkg::PAREN_BYTE) begin
          kanji_q     = 1'b0;
          esc_stage_q = ij2s_pkg::EP_SKIP;
        end else begin
          esc_stage_q = ij2s_pkg::EP_NONE;
          emitted.push_back(ij2s_pkg::ESC_BYTE);
          take_plain(b);
        end
      end
      ij2s_pkg::EP_DOLLAR: begin
        esc_stage_q = ij2s_pkg::EP_NONE;
        if (b == esc_final_q) begin
          kanji_q = 1'b1;
        end else begin
          emitted.push_back(ij2s_pkg::ESC_BYTE);
          take_plain(ij2s_pkg::DOLLAR_BYTE);
          take_plain(b);
        end
      end
      ij2s_pkg::EP_SKIP: begin
        esc_stage_q = ij2s_pkg::EP_NONE;
      end
      default: begin
        take_plain(b);
      end
    endcase
    if (last) begin
      // held escape bytes go out raw, a lone kanji byte is dropped
      if (esc_stage_q == ij2s_pkg::EP_ESC) begin
        emitted.push_back(ij2s_pkg::ESC_BYTE);
      end else if (esc_stage_q == ij2s_pkg::EP_DOLLAR) begin
        emitted.push_back(ij2s_pkg::ESC_BYTE);
        emitted.push_back(ij2s_pkg::DOLLAR_BYTE);
      end
      clear_stream_state();
    end
    n = (emitted.size() > ij2s_pkg::MAX_RESULTS) ? ij2s_pkg::MAX_RESULTS : emitted.size();
    for (int k = 0; k < n; k++) begin
      r.out_byte    = emitted[k];
      r.byte_valid  = 1'b1;
      r.string_done = last && (k == n - 1);
      sjis_expected.push_back(r);
    end
    if (last && n == 0) begin
      r.out_byte    = 8'h00;
      r.byte_valid  = 1'b0;
      r.string_done = 1'b1;
      sjis_expected.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    ij2s_pkg::result_t want;
    if (!rst_n) begin
      sjis_expected.delete();
      esc_final_q = ij2s_pkg::ESCAPE_FINAL_RESET;
      clear_stream_state();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sjis_expected.size() == 0) begin
          $error("result word with nothing expected: out_byte %h byte_valid %b string_done %b",
                 out_byte, out_byte_valid, out_done);
          mismatches++;
        end else begin
          want = sjis_expected.pop_front();
          checked++;
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_byte);
            mismatches++;
          end
          if (out_byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, out_byte_valid);
            mismatches++;
          end
          if (out_done !== want.string_done) begin
            $error("string_done: expected %b, got %b", want.string_done, out_done);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        esc_final_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_sjis(in_byte, in_last);
      end
    end
    awaited = sjis_expected.size();
  end

endmodule

FILE: verif/iso2022jp_to_shift_jis_converter_tb.sv
// Testbench top: drives byte strings and escape_final settings into the converter.
module iso2022jp_to_shift_jis_converter_tb;

  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_WORDS  = 28;

  logic clk = 1'b0;
  logic rst_n;

  ij2s_in_if  in_ch();
  ij2s_out_if out_ch();
  ij2s_cfg_if cfg_ch();

  int mismatches;
  int awaited;
  int checked;

  int         words_sent;
  int         strings_sent;
  int         cfg_writes;
  int         quiet_cycles;
  int         sink_hold;
  int         sink_calm;
  bit         idle_on;
  logic [7:0] cur_final;
  logic [7:0] text_q[$];
  logic [7:0] finals[7];

  always #2 clk = ~clk;

  iso2022jp_to_shift_jis_converter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sjis_stream_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_byte        (in_ch.data_byte),
    .in_last        (in_ch.end_of_string),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_byte_valid (out_ch.byte_valid),
    .out_done       (out_ch.string_done),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_data       (cfg_ch.data),
    .mismatches     (mismatches),
    .awaited        (awaited),
    .checked        (checked)
  );

  // mostly short gaps, a few long ones
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 7))
      0: return ij2s_pkg::ESC_BYTE;
      1: return ij2s_pkg::DOLLAR_BYTE;
      2: return ij2s_pkg::PAREN_BYTE;
      3: return cur_final;
      4: return 8'h00;
      5: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // result sink: random stalls with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
      sink_calm    <= 0;
    end else if (sink_hold != 0) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_calm != 0) begin
        sink_calm <= sink_calm - 1;
      end else if ($urandom_range(0, 9) == 0) begin
        sink_calm <= $urandom_range(30, 80);
      end else begin
        sink_hold <= gap_cycles();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int g;
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_string <= last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    words_sent++;
    g = idle_on ? gap_cycles() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_text();
    idle_on = ($urandom_range(0, 3) != 0);
    foreach (text_q[i]) begin
      send_word(text_q[i], i == text_q.size() - 1);
    end
    strings_sent++;
  endtask

  // well-formed escapes and kanji pairs, random noise bytes and broken escapes
  task automatic build_text();
    int segs;
    text_q.delete();
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        3, 4: begin
          text_q.push_back(ij2s_pkg::ESC_BYTE);
          text_q.push_back(ij2s_pkg::DOLLAR_BYTE);
          text_q.push_back(cur_final);
        end
        5, 6: begin
          repeat ($urandom_range(1, 3)) begin
            text_q.push_back(8'($urandom_range(0, 255)));
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        7: begin
          text_q.push_back(ij2s_pkg::ESC_BYTE);
          text_q.push_back(ij2s_pkg::PAREN_BYTE);
          text_q.push_back(odd_byte());
        end
        8: begin
          text_q.push_back(ij2s_pkg::ESC_BYTE);
          if ($urandom_range(0, 1) == 1) begin
            text_q.push_back(ij2s_pkg::DOLLAR_BYTE);
          end
          text_q.push_back(odd_byte());
        end
        default: begin
          text_q.push_back(odd_byte());
        end
      endcase
    end
  endtask

  task automatic write_escape_final(input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    cur_final = v;
    cfg_writes++;
  endtask

  // wait until every expected word is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.end_of_string = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = 8'h00;
    words_sent          = 0;
    strings_sent        = 0;
    cfg_writes          = 0;
    idle_on             = 1'b0;
    cur_final           = ij2s_pkg::ESCAPE_FINAL_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings under the reset escape_final
    text_q = '{8'h00, 8'hFF, ij2s_pkg::ESC_BYTE, ij2s_pkg::DOLLAR_BYTE,
               ij2s_pkg::ESCAPE_FINAL_RESET, 8'h21, 8'h7E, 8'hFF, 8'h80, 8'h00,
               ij2s_pkg::ESC_BYTE, ij2s_pkg::ESC_BYTE, ij2s_pkg::PAREN_BYTE, 8'h4A, 8'h41};
    send_text();
    text_q = '{ij2s_pkg::ESC_BYTE, ij2s_pkg::DOLLAR_BYTE, ij2s_pkg::ESC_BYTE};
    send_text();
    text_q = '{ij2s_pkg::ESC_BYTE, ij2s_pkg::DOLLAR_BYTE};
    send_text();
    text_q = '{ij2s_pkg::ESC_BYTE, ij2s_pkg::PAREN_BYTE};
    send_text();
    text_q = '{ij2s_pkg::ESC_BYTE, ij2s_pkg::DOLLAR_BYTE, ij2s_pkg::ESCAPE_FINAL_RESET, 8'h30};
    send_text();
    text_q = '{ij2s_pkg::ESC_BYTE, 8'h41};
    send_text();

    finals = '{8'h40, 8'h00, 8'hFF, ij2s_pkg::ESC_BYTE, ij2s_pkg::DOLLAR_BYTE, 8'h00,
               ij2s_pkg::ESCAPE_FINAL_RESET};
    finals[5] = 8'($urandom_range(0, 255));
    foreach (finals[p]) begin
      drain();
      write_escape_final(finals[p]);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        build_text();
        send_text();
      end
    end
    drain();

    $display("sent %0d input words in %0d strings, checked %0d result words",
             words_sent, strings_sent, checked);
    $display("escape_final went through %0d settings, 0x00 and 0xFF among them", cfg_writes);
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: iso2022jp_to_shift_jis_converter.f
hdl/ij2s_pkg.sv
hdl/ij2s_if.sv
hdl/ij2s_decode.sv
hdl/ij2s_outbuf.sv
hdl/iso2022jp_to_shift_jis_converter.sv
verif/sjis_stream_checker.sv
verif/iso2022jp_to_shift_jis_converter_tb.sv
